// ===== sv/als_pkg.sv =====
`timescale 1ns / 1ps

package als_pkg;

  localparam int COUNT_W = 16;
  localparam int LUX_W   = 20;
  localparam int CH_FRAC_BITS    = 10;
  localparam int RATIO_FRAC_BITS = 9;
  localparam int LUX_FRAC_BITS   = 14;

  // count scale: 15-bit base, times 16 at low gain
  localparam int SCALE_W = 19;
  // scaled channel value: count * scale >> CH_FRAC_BITS
  localparam int CH_W    = COUNT_W + SCALE_W - CH_FRAC_BITS;
  // segment coefficient width
  localparam int COEF_W  = 10;
  // lux product width
  localparam int PROD_W  = CH_W + COEF_W;

  localparam logic [SCALE_W-1:0] SCALE_SHORT   = 19'h07517;
  localparam logic [SCALE_W-1:0] SCALE_MEDIUM  = 19'h00fe7;
  localparam logic [SCALE_W-1:0] SCALE_NOMINAL = 19'h00400;

  localparam logic [1:0] IT_SHORT  = 2'd0;
  localparam logic [1:0] IT_MEDIUM = 2'd1;
  localparam logic [1:0] IT_RESET  = 2'd2;

  // configuration register indexes
  localparam logic [0:0] REG_INTEG_TIME = 1'b0;
  localparam logic [0:0] REG_GAIN_HIGH  = 1'b1;

  localparam int SEGMENTS = 8;
  localparam int SEG_W    = 3;
  // last segment (zero coefficients) also serves ratios beyond every breakpoint
  localparam logic [SEG_W-1:0] SEG_NONE = 3'd7;

  localparam logic [COEF_W:0] SEG_BREAK [SEGMENTS] = '{
    11'h040, 11'h080, 11'h0c0, 11'h100, 11'h138, 11'h19a, 11'h29a, 11'h29a
  };
  localparam logic [COEF_W-1:0] SEG_B [SEGMENTS] = '{
    10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000
  };
  localparam logic [COEF_W-1:0] SEG_M [SEGMENTS] = '{
    10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000
  };

endpackage

// ===== sv/als_scale.sv =====
`timescale 1ns / 1ps

module als_scale (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           in_valid,
  input  logic [1:0]                     integration_time,
  input  logic                           gain_high,
  input  logic [als_pkg::COUNT_W-1:0]    broadband_count,
  input  logic [als_pkg::COUNT_W-1:0]    infrared_count,
  output logic                           out_valid,
  output logic [als_pkg::CH_W-1:0]       ch0,
  output logic [als_pkg::CH_W-1:0]       ch1
);

  localparam int MUL_W = als_pkg::COUNT_W + als_pkg::SCALE_W;

  logic [als_pkg::SCALE_W-1:0] base;
  logic [als_pkg::SCALE_W-1:0] scale;
  logic [als_pkg::COUNT_W+als_pkg::SCALE_W-1:0] prod0;
  logic [als_pkg::COUNT_W+als_pkg::SCALE_W-1:0] prod1;

  always_comb begin
    case (integration_time)
      als_pkg::IT_SHORT:  base = als_pkg::SCALE_SHORT;
      als_pkg::IT_MEDIUM: base = als_pkg::SCALE_MEDIUM;
      default:            base = als_pkg::SCALE_NOMINAL;
    endcase
    scale = gain_high ? base : (base << 4);
    prod0 = MUL_W'(broadband_count) * MUL_W'(scale);
    prod1 = MUL_W'(infrared_count) * MUL_W'(scale);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      ch0 <= prod0[als_pkg::COUNT_W+als_pkg::SCALE_W-1:als_pkg::CH_FRAC_BITS];
      ch1 <= prod1[als_pkg::COUNT_W+als_pkg::SCALE_W-1:als_pkg::CH_FRAC_BITS];
    end
  end

endmodule

// ===== sv/als_seg.sv =====
`timescale 1ns / 1ps

// Segment pick without a divide: rounded ratio <= brk holds exactly when
// ch1 << 10 < (2*brk + 1) * ch0. A zero ch0 matches no segment, which
// gives zero coefficients and zero lux, as the first segment would.
module als_seg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [als_pkg::CH_W-1:0]     in_ch0,
  input  logic [als_pkg::CH_W-1:0]     in_ch1,
  output logic                         out_valid,
  output logic [als_pkg::CH_W-1:0]     ch0,
  output logic [als_pkg::CH_W-1:0]     ch1,
  output logic [als_pkg::SEG_W-1:0]    seg
);

  localparam int CMP_W = als_pkg::CH_W + als_pkg::COEF_W + 1;

  logic [CMP_W-1:0]             lhs;
  logic [CMP_W-1:0]             rhs [als_pkg::SEGMENTS-1];
  logic [als_pkg::SEGMENTS-2:0] hit;
  logic [als_pkg::SEG_W-1:0]    seg_next;

  always_comb begin
    lhs = {1'b0, in_ch1, {(als_pkg::RATIO_FRAC_BITS + 1){1'b0}}};
    for (int i = 0; i < als_pkg::SEGMENTS - 1; i++) begin
      rhs[i] = CMP_W'(in_ch0) * CMP_W'({als_pkg::SEG_BREAK[i][als_pkg::COEF_W-1:0], 1'b1});
      hit[i] = lhs < rhs[i];
    end
    seg_next = als_pkg::SEG_NONE;
    for (int i = als_pkg::SEGMENTS - 2; i >= 0; i--) begin
      if (hit[i]) begin
        seg_next = i[als_pkg::SEG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      ch0 <= in_ch0;
      ch1 <= in_ch1;
      seg <= seg_next;
    end
  end

  a_zero_ch0_no_seg: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ch0 == '0) |-> (seg == als_pkg::SEG_NONE))
    else $error("zero broadband picked a live segment");

endmodule

// ===== sv/als_lux.sv =====
`timescale 1ns / 1ps

module als_lux (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv_prod,
  input  logic                         adv_out,
  input  logic                         in_valid,
  input  logic [als_pkg::CH_W-1:0]     ch0,
  input  logic [als_pkg::CH_W-1:0]     ch1,
  input  logic [als_pkg::SEG_W-1:0]    seg,
  output logic                         prod_valid,
  output logic                         out_valid,
  output logic [als_pkg::LUX_W-1:0]    lux
);

  localparam int MUL_W = als_pkg::PROD_W;
  localparam int ACC_W = als_pkg::PROD_W + 1;
  localparam int SHR_W = ACC_W - als_pkg::LUX_FRAC_BITS;

  logic [als_pkg::PROD_W-1:0] pos;
  logic [als_pkg::PROD_W-1:0] neg;
  logic [als_pkg::PROD_W-1:0] diff;
  logic [ACC_W-1:0]           acc;
  logic [SHR_W-1:0]           shr;
  logic [als_pkg::LUX_W-1:0]  lux_next;

  // stage 3: the two coefficient products
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (adv_prod) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_prod && in_valid) begin
      pos <= MUL_W'(ch0) * MUL_W'(als_pkg::SEG_B[seg]);
      neg <= MUL_W'(ch1) * MUL_W'(als_pkg::SEG_M[seg]);
    end
  end

  // stage 4: clamp, round, saturate
  always_comb begin
    diff = (pos > neg) ? (pos - neg) : '0;
    acc  = {1'b0, diff} + (ACC_W'(1) << (als_pkg::LUX_FRAC_BITS - 1));
    shr  = acc[ACC_W-1:als_pkg::LUX_FRAC_BITS];
    if (shr > SHR_W'({als_pkg::LUX_W{1'b1}})) begin
      lux_next = '1;
    end else begin
      lux_next = shr[als_pkg::LUX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && prod_valid) begin
      lux <= lux_next;
    end
  end

  a_dead_seg_zero: assert property (@(posedge clk) disable iff (rst)
    (adv_prod && in_valid && seg == als_pkg::SEG_NONE) |=> (pos == '0 && neg == '0))
    else $error("out-of-range segment left nonzero products");

endmodule

// ===== sv/ambient_light_lux_calc_core.sv =====
`timescale 1ns / 1ps

// Lux calculator for a two-channel (broadband / infrared) photodiode sensor.
// Input stream: s_tvalid/s_tready/s_tdata carries one pair of raw counts per
// item. Output stream: m_tvalid/m_tready/m_tdata carries one lux value per
// input item, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0: integration time code, 1: high gain flag). Write only while the block
// holds no item.
// Pipeline: four register stages (count scaling, segment pick by constant
// multiply-compare, coefficient products, clamp/round). An item passes them
// in that order and m_tvalid rises when it reaches the clamp/round register;
// one item per cycle is accepted as long as m_tready stays high.
// Back-pressure: when m_tready is low, stages fill up behind the output
// register; s_tready drops only once every stage holds an item. Nothing is
// dropped or repeated.
// Reset (rst, synchronous): empties the pipeline and sets integration time to
// nominal and gain to 1x.
module ambient_light_lux_calc_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] broadband_count, [31:16] infrared_count
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [19:0] lux, [23:20] zero
);

  logic [1:0] integration_time;
  logic       gain_high;

  logic en1, en2, en3, en4;
  logic v1, v2, v3;

  logic [als_pkg::CH_W-1:0]  s1_ch0, s1_ch1, s2_ch0, s2_ch1;
  logic [als_pkg::SEG_W-1:0] s2_seg;
  logic [als_pkg::LUX_W-1:0] lux;

  always_ff @(posedge clk) begin
    if (rst) begin
      integration_time <= als_pkg::IT_RESET;
      gain_high        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        als_pkg::REG_INTEG_TIME: integration_time <= cfg_data;
        als_pkg::REG_GAIN_HIGH:  gain_high        <= cfg_data[0];
      endcase
    end
  end

  // a stage moves when it is empty or the next one moves
  assign en4 = !m_tvalid || m_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  als_scale u_scale (
    .clk              (clk),
    .rst              (rst),
    .adv              (en1),
    .in_valid         (s_tvalid),
    .integration_time (integration_time),
    .gain_high        (gain_high),
    .broadband_count  (s_tdata[15:0]),
    .infrared_count   (s_tdata[31:16]),
    .out_valid        (v1),
    .ch0              (s1_ch0),
    .ch1              (s1_ch1)
  );

  als_seg u_seg (
    .clk       (clk),
    .rst       (rst),
    .adv       (en2),
    .in_valid  (v1),
    .in_ch0    (s1_ch0),
    .in_ch1    (s1_ch1),
    .out_valid (v2),
    .ch0       (s2_ch0),
    .ch1       (s2_ch1),
    .seg       (s2_seg)
  );

  als_lux u_lux (
    .clk        (clk),
    .rst        (rst),
    .adv_prod   (en3),
    .adv_out    (en4),
    .in_valid   (v2),
    .ch0        (s2_ch0),
    .ch1        (s2_ch1),
    .seg        (s2_seg),
    .prod_valid (v3),
    .out_valid  (m_tvalid),
    .lux        (lux)
  );

  assign m_tdata = {4'b0, lux};

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while every stage is full and stalled");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !v1 && !v2 && !v3))
    else $error("pipeline not empty after reset");

  a_free_takes_input: assert property (@(posedge clk) disable iff (rst)
    (!v1 || m_tready) |-> s_tready)
    else $error("input stalled with room in the pipeline");

endmodule

// ===== tb/ambient_light_lux_calc_core_test.sv =====
`timescale 1ns / 1ps

module ambient_light_lux_calc_core_test;

  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = 12;
  // code 3 scales like the nominal code 2
  localparam logic [1:0] IT_NOMINAL_ALT = 2'd3;

  typedef struct packed {
    logic [15:0] bb;
    logic [15:0] ir;
    logic [1:0]  itime;
    logic [1:0]  gain_val;
    logic        has_lux;
    logic [19:0] lux;
  } probe_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = als_pkg::REG_INTEG_TIME;
  logic [1:0]  cfg_data = 2'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = 32'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  logic [19:0] lux_q[$];
  logic [19:0] want_lux;
  probe_t      probes[$];
  logic [1:0]  it_now = als_pkg::IT_RESET;
  logic        gain_now = 1'b0;
  int          send_pct = 0;
  int          stall_pct = 0;
  int          hold_cycles = 0;
  int          mismatches = 0;
  int          cycles = 0;

  ambient_light_lux_calc_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [15:0] broadband_count, [31:16] infrared_count
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [19:0] lux, [23:20] zero
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [19:0] predict_lux(input logic [15:0] bb, ir,
                                              input logic [1:0] itime,
                                              input logic gain);
    logic [63:0] scale, ch0, ch1, ratio, b, m, pos, neg, acc;
    if (itime == als_pkg::IT_SHORT) scale = 64'(als_pkg::SCALE_SHORT);
    else if (itime == als_pkg::IT_MEDIUM) scale = 64'(als_pkg::SCALE_MEDIUM);
    else scale = 64'(als_pkg::SCALE_NOMINAL);
    if (!gain) scale = scale << 4;
    ch0 = (64'(bb) * scale) >> als_pkg::CH_FRAC_BITS;
    ch1 = (64'(ir) * scale) >> als_pkg::CH_FRAC_BITS;
    ratio = 64'd0;
    if (ch0 != 64'd0) ratio = (ch1 << (als_pkg::RATIO_FRAC_BITS + 1)) / ch0;
    ratio = (ratio + 64'd1) >> 1;
    // piecewise segments: intercept b, slope m
    if (ratio <= 64'h040) begin b = 64'h1f2; m = 64'h1be; end
    else if (ratio <= 64'h080) begin b = 64'h214; m = 64'h2d1; end
    else if (ratio <= 64'h0c0) begin b = 64'h23f; m = 64'h37b; end
    else if (ratio <= 64'h100) begin b = 64'h270; m = 64'h3fe; end
    else if (ratio <= 64'h138) begin b = 64'h16f; m = 64'h1fc; end
    else if (ratio <= 64'h19a) begin b = 64'h0d2; m = 64'h0fb; end
    else if (ratio <= 64'h29a) begin b = 64'h018; m = 64'h012; end
    else begin b = 64'd0; m = 64'd0; end
    pos = ch0 * b;
    neg = ch1 * m;
    acc = (pos > neg) ? (pos - neg) : 64'd0;
    acc = (acc + (64'd1 << (als_pkg::LUX_FRAC_BITS - 1))) >> als_pkg::LUX_FRAC_BITS;
    if (acc > 64'hfffff) return 20'hfffff;
    return acc[19:0];
  endfunction

  function automatic probe_t row(input logic [15:0] bb, ir, input logic [1:0] itime,
                                 input logic [1:0] gain_val, input logic has_lux,
                                 input logic [19:0] lux);
    probe_t p;
    p.bb = bb;
    p.ir = ir;
    p.itime = itime;
    p.gain_val = gain_val;
    p.has_lux = has_lux;
    p.lux = lux;
    return p;
  endfunction

  // receiver: random stalls, or a counted hold-off when requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (lux_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected lux item: got %0d (tdata %h)", m_tdata[19:0], m_tdata);
        mismatches = mismatches + 1;
      end else begin
        want_lux = lux_q.pop_front();
        if (m_tdata !== {4'h0, want_lux}) begin
          if (mismatches < MAX_REPORTS)
            $display("lux mismatch: expected %0d got %0d (tdata %h)",
                     want_lux, m_tdata[19:0], m_tdata);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // entered and left at a falling edge; tvalid stays up for a back-to-back item
  task automatic send_pair(input logic [15:0] bb, ir, input logic [19:0] lux);
    while ($urandom_range(99) < send_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ir, bb};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    lux_q.push_back(lux);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (lux_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [1:0] itime, gain_val);
    write_reg(als_pkg::REG_INTEG_TIME, itime);
    write_reg(als_pkg::REG_GAIN_HIGH, gain_val);
    it_now = itime;
    gain_now = gain_val[0];
  endtask

  task automatic pick_pair(output logic [15:0] bb, ir);
    int unsigned r, prod;
    case ($urandom_range(3))
      0: begin
        bb = 16'($urandom);
        ir = 16'($urandom);
      end
      1: begin
        // sweep the ir/bb ratio across every segment and past the last
        bb = 16'($urandom);
        r = $urandom_range(1400);
        prod = (32'(bb) * r) >> 10;
        ir = (prod > 32'hffff) ? 16'hffff : prod[15:0];
      end
      2: begin
        bb = 16'($urandom_range(20));
        ir = 16'($urandom_range(20));
      end
      default: begin
        bb = $urandom_range(1) ? 16'hffff : 16'($urandom_range(3));
        ir = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3));
      end
    endcase
  endtask

  task automatic run_phase(input logic [1:0] itime, gain_val,
                           input int send_idle, stall, count, hold);
    logic [15:0] bb, ir;
    wait_drain();
    set_config(itime, gain_val);
    send_pct = send_idle;
    stall_pct = stall;
    if (hold > 0) hold_cycles = hold;
    repeat (count) begin
      pick_pair(bb, ir);
      send_pair(bb, ir, predict_lux(bb, ir, it_now, gain_now));
    end
  endtask

  initial begin
    probe_t p;
    // reset settings (nominal time, 1x gain) come first, with no write
    probes.push_back(row(16'd0, 16'd0, als_pkg::IT_RESET, 2'd0, 1'b1, 20'd0));
    probes.push_back(row(16'd0, 16'hffff, als_pkg::IT_RESET, 2'd0, 1'b1, 20'd0));
    probes.push_back(row(16'hffff, 16'd0, als_pkg::IT_RESET, 2'd0, 1'b1, 20'd31872));
    probes.push_back(row(16'hffff, 16'hffff, als_pkg::IT_RESET, 2'd0, 1'b0, 20'd0));
    probes.push_back(row(16'd1, 16'd0, als_pkg::IT_RESET, 2'd0, 1'b0, 20'd0));
    // unit scale: ratio boundaries on either side of each breakpoint
    probes.push_back(row(16'd1024, 16'd128, IT_NOMINAL_ALT, 2'd1, 1'b0, 20'd0));
    probes.push_back(row(16'd1024, 16'd129, IT_NOMINAL_ALT, 2'd1, 1'b0, 20'd0));
    probes.push_back(row(16'd1024, 16'd256, IT_NOMINAL_ALT, 2'd1, 1'b0, 20'd0));
    probes.push_back(row(16'd1024, 16'd257, IT_NOMINAL_ALT, 2'd1, 1'b0, 20'd0));
    probes.push_back(row(16'd1024, 16'd384, IT_NOMINAL_ALT, 2'd1, 1'b0, 20'd0));
    probes.push_back(row(16'd1024, 16'd385, IT_NOMINAL_ALT, 2'd1, 1'b0, 20'd0));
    probes.push_back(row(16'd1024, 16'd512, IT_NOMINAL_ALT, 2'd1, 1'b0, 20'd0));
    probes.push_back(row(16'd1024, 16'd513, IT_NOMINAL_ALT, 2'd1, 1'b0, 20'd0));
    probes.push_back(row(16'd1024, 16'd624, IT_NOMINAL_ALT, 2'd1, 1'b0, 20'd0));
    probes.push_back(row(16'd1024, 16'd625, IT_NOMINAL_ALT, 2'd1, 1'b0, 20'd0));
    probes.push_back(row(16'd1024, 16'd820, IT_NOMINAL_ALT, 2'd1, 1'b0, 20'd0));
    probes.push_back(row(16'd1024, 16'd821, IT_NOMINAL_ALT, 2'd1, 1'b0, 20'd0));
    probes.push_back(row(16'd1024, 16'd1332, IT_NOMINAL_ALT, 2'd1, 1'b0, 20'd0));
    probes.push_back(row(16'd1024, 16'd1333, IT_NOMINAL_ALT, 2'd1, 1'b1, 20'd0));
    probes.push_back(row(16'hffff, 16'd0, IT_NOMINAL_ALT, 2'd1, 1'b1, 20'd1992));
    // short time at 1x gain gives the largest lux
    probes.push_back(row(16'hffff, 16'd0, als_pkg::IT_SHORT, 2'd0, 1'b1, 20'd932958));
    probes.push_back(row(16'hffff, 16'hffff, als_pkg::IT_SHORT, 2'd0, 1'b0, 20'd0));
    // gain register only looks at bit 0
    probes.push_back(row(16'd40000, 16'd12000, als_pkg::IT_MEDIUM, 2'd2, 1'b0, 20'd0));
    probes.push_back(row(16'hffff, 16'd0, als_pkg::IT_MEDIUM, 2'd3, 1'b0, 20'd0));
    probes.push_back(row(16'd12345, 16'd54321, als_pkg::IT_MEDIUM, 2'd1, 1'b1, 20'd0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (probes[i]) begin
      p = probes[i];
      if (p.itime != it_now || p.gain_val[0] != gain_now || p.gain_val[1]) begin
        wait_drain();
        set_config(p.itime, p.gain_val);
      end
      send_pair(p.bb, p.ir,
                p.has_lux ? p.lux : predict_lux(p.bb, p.ir, it_now, gain_now));
    end

    run_phase(als_pkg::IT_RESET, 2'd0, 0, 0, 120, 0);
    run_phase(als_pkg::IT_SHORT, 2'd1, 78, 0, 120, 0);
    run_phase(als_pkg::IT_MEDIUM, 2'd0, 0, 78, 120, 0);
    run_phase(IT_NOMINAL_ALT, 2'd3, 26, 26, 120, 0);
    // long output hold-off while items keep coming: input must back up
    run_phase(als_pkg::IT_SHORT, 2'd0, 0, 0, 40, 400);
    run_phase(als_pkg::IT_SHORT, 2'd0, 0, 0, 120, 0);
    run_phase(2'($urandom_range(3)), 2'($urandom_range(3)), 78, 0, 120, 0);
    run_phase(als_pkg::IT_MEDIUM, 2'd1, 0, 78, 120, 0);
    run_phase(2'($urandom_range(3)), 2'($urandom_range(3)), 26, 26, 120, 0);

    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && lux_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
